### hw/rtl/phmm_occ_pkg.sv
// package for the profile-hmm state occupancy core
// fixed-point widths, controller codes and command/status structs
// no dependencies
package phmm_occ_pkg;

    localparam int FRAC_BITS = 15;
    localparam int P_W       = FRAC_BITS + 1;
    localparam int M_W       = P_W + 2;
    localparam int D_W       = P_W + 1;
    localparam int S_W       = M_W;
    localparam int PR_W      = M_W + P_W;
    localparam int Q_W       = P_W;
    localparam int N_W       = M_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(Q_W);

    localparam logic [P_W-1:0]  ONE_Q  = P_W'(1) << FRAC_BITS;
    localparam logic [PR_W-1:0] HALF_Q = PR_W'(1) << (FRAC_BITS - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(Q_W - 1);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_START_DELETE = CFG_ADDR_W'(0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MS_MM,
        MS_DM,
        MS_MD,
        MS_DD,
        MS_MI
    } mul_step_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        mul_step_t mul_step;
        logic      div_start;
        logic      div_step;
        logic      commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [P_W-1:0] sat_one(input logic [P_W-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

endpackage

### hw/rtl/phmm_occ_div.sv
// restoring divider, one quotient bit per cycle while step is high, rounded q1.x quotient
// depends on phmm_occ_pkg
module phmm_occ_div (
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [phmm_occ_pkg::M_W-1:0] num,
    input  logic [phmm_occ_pkg::S_W-1:0] sum,
    output logic [phmm_occ_pkg::Q_W-1:0] quo
);

    logic [phmm_occ_pkg::S_W-1:0] rem_reg, rem_next;
    logic [phmm_occ_pkg::Q_W-1:0] quo_reg, quo_next;
    logic [phmm_occ_pkg::S_W-1:0] sum_reg, sum_next;
    logic [phmm_occ_pkg::N_W-1:0] dividend;
    logic [phmm_occ_pkg::S_W:0]   trial;
    logic [phmm_occ_pkg::S_W:0]   diff;
    logic                         ge;

    always_comb
    begin
        dividend = {num, {phmm_occ_pkg::FRAC_BITS{1'b0}}}
                 + phmm_occ_pkg::N_W'(sum >> 1);
        trial    = {rem_reg, quo_reg[phmm_occ_pkg::Q_W-1]};
        ge       = trial >= {1'b0, sum_reg};
        diff     = trial - {1'b0, sum_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        sum_next = sum_reg;
        if (start)
        begin
            rem_next = phmm_occ_pkg::S_W'(dividend[phmm_occ_pkg::N_W-1:phmm_occ_pkg::Q_W]);
            quo_next = dividend[phmm_occ_pkg::Q_W-1:0];
            sum_next = sum;
        end
        else if (step)
        begin
            rem_next = ge ? diff[phmm_occ_pkg::S_W-1:0] : trial[phmm_occ_pkg::S_W-1:0];
            quo_next = {quo_reg[phmm_occ_pkg::Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sum_reg <= sum_next;
    end

    assign quo = quo_reg;

endmodule

### hw/rtl/phmm_occ_dp.sv
// datapath: operand capture, shared multiplier, two dividers, held state, result register
// depends on phmm_occ_pkg and phmm_occ_div
module phmm_occ_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  phmm_occ_pkg::dp_cmd_t        cmd,
    output phmm_occ_pkg::dp_stat_t       stat,
    input  logic                         is_first,
    input  logic                         is_last,
    input  logic [phmm_occ_pkg::P_W-1:0] begin_prob,
    input  logic [phmm_occ_pkg::P_W-1:0] prev_match_to_match,
    input  logic [phmm_occ_pkg::P_W-1:0] prev_match_to_delete,
    input  logic [phmm_occ_pkg::P_W-1:0] prev_delete_to_match,
    input  logic [phmm_occ_pkg::P_W-1:0] prev_delete_to_delete,
    input  logic [phmm_occ_pkg::P_W-1:0] match_to_insert,
    input  logic [phmm_occ_pkg::P_W-1:0] start_delete,
    input  logic                         result_stall,
    output logic                         result_valid,
    output logic [phmm_occ_pkg::P_W-1:0] match_occupancy,
    output logic [phmm_occ_pkg::P_W-1:0] delete_occupancy,
    output logic [phmm_occ_pkg::P_W-1:0] insert_occupancy,
    output logic                         last_node
);

    localparam int P_W  = phmm_occ_pkg::P_W;
    localparam int M_W  = phmm_occ_pkg::M_W;
    localparam int D_W  = phmm_occ_pkg::D_W;
    localparam int PR_W = phmm_occ_pkg::PR_W;
    localparam int FB   = phmm_occ_pkg::FRAC_BITS;

    logic [P_W-1:0] begin_reg, mm_reg, md_reg, dm_reg, dd_reg, mi_reg;
    logic           first_reg, last_reg;
    logic [M_W-1:0] m_acc_reg, m_acc_next;
    logic [D_W-1:0] d_acc_reg, d_acc_next;
    logic [P_W-1:0] ins_reg, ins_next;

    logic [P_W-1:0] held_match_reg, held_delete_reg, held_insert_reg;

    logic           res_valid_reg, res_valid_next;
    logic [P_W-1:0] res_match_reg, res_delete_reg, res_insert_reg;
    logic           res_last_reg;

    logic [M_W-1:0]  mul_a;
    logic [P_W-1:0]  mul_b;
    logic [PR_W-1:0] prod, prod_rnd;
    logic [PR_W-FB-1:0] rnd;

    logic [M_W-1:0] div_sum;
    logic [P_W-1:0] quo_m, quo_d;
    logic           sum_zero;
    logic [P_W-1:0] m_out, d_out;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_step)
            phmm_occ_pkg::MS_MM:
            begin
                mul_a = M_W'(held_match_reg);
                mul_b = mm_reg;
            end
            phmm_occ_pkg::MS_DM:
            begin
                mul_a = M_W'(held_delete_reg);
                mul_b = dm_reg;
            end
            phmm_occ_pkg::MS_MD:
            begin
                mul_a = M_W'(held_match_reg);
                mul_b = md_reg;
            end
            phmm_occ_pkg::MS_DD:
            begin
                mul_a = M_W'(held_delete_reg);
                mul_b = dd_reg;
            end
            phmm_occ_pkg::MS_MI:
            begin
                mul_a = m_acc_reg;
                mul_b = mi_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod     = PR_W'(mul_a) * PR_W'(mul_b);
        prod_rnd = prod + phmm_occ_pkg::HALF_Q;
        rnd      = prod_rnd[PR_W-1:FB];
    end

    always_comb
    begin
        m_acc_next = m_acc_reg;
        d_acc_next = d_acc_reg;
        ins_next   = ins_reg;
        if (cmd.load)
        begin
            m_acc_next = is_first
                       ? M_W'(phmm_occ_pkg::sat_one(begin_prob))
                       : M_W'(held_insert_reg) + M_W'(phmm_occ_pkg::sat_one(begin_prob));
            d_acc_next = '0;
        end
        else if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                phmm_occ_pkg::MS_MM, phmm_occ_pkg::MS_DM:
                    m_acc_next = m_acc_reg + rnd[M_W-1:0];
                phmm_occ_pkg::MS_MD, phmm_occ_pkg::MS_DD:
                    d_acc_next = d_acc_reg + rnd[D_W-1:0];
                phmm_occ_pkg::MS_MI:
                    ins_next = last_reg ? '0
                             : ((rnd > (PR_W-FB)'(phmm_occ_pkg::ONE_Q))
                                ? phmm_occ_pkg::ONE_Q : rnd[P_W-1:0]);
                default:
                    ins_next = ins_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            begin_reg <= phmm_occ_pkg::sat_one(begin_prob);
            mm_reg    <= phmm_occ_pkg::sat_one(prev_match_to_match);
            md_reg    <= phmm_occ_pkg::sat_one(prev_match_to_delete);
            dm_reg    <= phmm_occ_pkg::sat_one(prev_delete_to_match);
            dd_reg    <= phmm_occ_pkg::sat_one(prev_delete_to_delete);
            mi_reg    <= phmm_occ_pkg::sat_one(match_to_insert);
            first_reg <= is_first;
            last_reg  <= is_last;
        end
        m_acc_reg <= m_acc_next;
        d_acc_reg <= d_acc_next;
        ins_reg   <= ins_next;
    end

    assign div_sum  = m_acc_reg + M_W'(d_acc_reg);
    assign sum_zero = (m_acc_reg == '0) && (d_acc_reg == '0);

    phmm_occ_div u_div_match (
        .clk   (clk),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .num   (m_acc_reg),
        .sum   (div_sum),
        .quo   (quo_m)
    );

    phmm_occ_div u_div_delete (
        .clk   (clk),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .num   (M_W'(d_acc_reg)),
        .sum   (div_sum),
        .quo   (quo_d)
    );

    always_comb
    begin
        if (first_reg)
        begin
            m_out = begin_reg;
            d_out = phmm_occ_pkg::sat_one(start_delete);
        end
        else if (sum_zero)
        begin
            m_out = '0;
            d_out = '0;
        end
        else
        begin
            m_out = phmm_occ_pkg::sat_one(quo_m);
            d_out = phmm_occ_pkg::sat_one(quo_d);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.commit)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            held_match_reg  <= '0;
            held_delete_reg <= '0;
            held_insert_reg <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd.commit)
            begin
                held_match_reg  <= m_out;
                held_delete_reg <= d_out;
                held_insert_reg <= ins_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_match_reg  <= m_out;
            res_delete_reg <= d_out;
            res_insert_reg <= ins_reg;
            res_last_reg   <= last_reg;
        end
    end

    assign stat.out_free    = !res_valid_reg || !result_stall;
    assign result_valid     = res_valid_reg;
    assign match_occupancy  = res_match_reg;
    assign delete_occupancy = res_delete_reg;
    assign insert_occupancy = res_insert_reg;
    assign last_node        = res_last_reg;

endmodule

### hw/rtl/phmm_occ_ctrl.sv
// controller: sequences capture, multiply steps, division and result commit
// depends on phmm_occ_pkg
module phmm_occ_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   is_first,
    output logic                   item_stall,
    input  phmm_occ_pkg::dp_stat_t stat,
    output phmm_occ_pkg::dp_cmd_t  cmd
);

    phmm_occ_pkg::ctrl_state_t state_reg, state_next;
    phmm_occ_pkg::mul_step_t   step_reg, step_next;
    logic [phmm_occ_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic                      first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phmm_occ_pkg::ST_IDLE;
            step_reg  <= phmm_occ_pkg::MS_MM;
            dcnt_reg  <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dcnt_reg  <= dcnt_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        dcnt_next     = dcnt_reg;
        first_next    = first_reg;
        item_stall    = 1'b1;
        cmd           = '0;
        cmd.mul_step  = step_reg;
        case (state_reg)
            phmm_occ_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = is_first;
                    step_next  = is_first ? phmm_occ_pkg::MS_MI : phmm_occ_pkg::MS_MM;
                    state_next = phmm_occ_pkg::ST_MUL;
                end
            end
            phmm_occ_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == phmm_occ_pkg::MS_MI)
                    state_next = first_reg ? phmm_occ_pkg::ST_DONE
                                           : phmm_occ_pkg::ST_DIV_LOAD;
                else
                    step_next = phmm_occ_pkg::mul_step_t'(step_reg + 3'd1);
            end
            phmm_occ_pkg::ST_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                dcnt_next     = '0;
                state_next    = phmm_occ_pkg::ST_DIV;
            end
            phmm_occ_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == phmm_occ_pkg::DCNT_LAST)
                    state_next = phmm_occ_pkg::ST_DONE;
            end
            phmm_occ_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = phmm_occ_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phmm_occ_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/profile_hmm_state_occupancy_core.sv
// profile-hmm state occupancy core: one node per transfer, one result per node
// path: node one goes from capture through the insert multiply step to commit; later nodes run
// five shared multiply steps, a divider load, then the two bit-serial dividers in parallel
// one node in flight at a time: the next is taken after commit, which waits on a full result register
// reset: asynchronous active-low, clears control, held occupancies and start_delete_prob
// depends on phmm_occ_pkg, phmm_occ_ctrl, phmm_occ_dp
module profile_hmm_state_occupancy_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phmm_occ_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [phmm_occ_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [phmm_occ_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                is_first,
    input  logic                                is_last,
    input  logic [phmm_occ_pkg::P_W-1:0]        begin_prob,
    input  logic [phmm_occ_pkg::P_W-1:0]        prev_match_to_match,
    input  logic [phmm_occ_pkg::P_W-1:0]        prev_match_to_delete,
    input  logic [phmm_occ_pkg::P_W-1:0]        prev_delete_to_match,
    input  logic [phmm_occ_pkg::P_W-1:0]        prev_delete_to_delete,
    input  logic [phmm_occ_pkg::P_W-1:0]        match_to_insert,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [phmm_occ_pkg::P_W-1:0]        match_occupancy,
    output logic [phmm_occ_pkg::P_W-1:0]        delete_occupancy,
    output logic [phmm_occ_pkg::P_W-1:0]        insert_occupancy,
    output logic                                last_node
);

    phmm_occ_pkg::dp_cmd_t  cmd;
    phmm_occ_pkg::dp_stat_t stat;

    logic [phmm_occ_pkg::P_W-1:0] start_delete_reg, start_delete_next;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr == phmm_occ_pkg::ADDR_START_DELETE);

    always_comb
    begin
        start_delete_next = start_delete_reg;
        if (cfg_wr)
            start_delete_next = pwdata[phmm_occ_pkg::P_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_delete_reg <= '0;
        else
            start_delete_reg <= start_delete_next;
    end

    assign prdata = (paddr == phmm_occ_pkg::ADDR_START_DELETE)
                  ? phmm_occ_pkg::CFG_DATA_W'(start_delete_reg) : '0;

    phmm_occ_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .is_first   (is_first),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    phmm_occ_dp u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .is_first              (is_first),
        .is_last               (is_last),
        .begin_prob            (begin_prob),
        .prev_match_to_match   (prev_match_to_match),
        .prev_match_to_delete  (prev_match_to_delete),
        .prev_delete_to_match  (prev_delete_to_match),
        .prev_delete_to_delete (prev_delete_to_delete),
        .match_to_insert       (match_to_insert),
        .start_delete          (start_delete_reg),
        .result_stall          (result_stall),
        .result_valid          (result_valid),
        .match_occupancy       (match_occupancy),
        .delete_occupancy      (delete_occupancy),
        .insert_occupancy      (insert_occupancy),
        .last_node             (last_node)
    );

endmodule

### hw/rtl/phmm_occ_checker.sv
// port-level checks for the profile-hmm state occupancy core
// depends on phmm_occ_pkg; bound to profile_hmm_state_occupancy_core
module phmm_occ_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [phmm_occ_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [phmm_occ_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [phmm_occ_pkg::CFG_DATA_W-1:0] prdata,
    input logic                                pready,
    input logic                                item_valid,
    input logic                                item_stall,
    input logic                                is_first,
    input logic                                is_last,
    input logic [phmm_occ_pkg::P_W-1:0]        begin_prob,
    input logic [phmm_occ_pkg::P_W-1:0]        prev_match_to_match,
    input logic [phmm_occ_pkg::P_W-1:0]        prev_match_to_delete,
    input logic [phmm_occ_pkg::P_W-1:0]        prev_delete_to_match,
    input logic [phmm_occ_pkg::P_W-1:0]        prev_delete_to_delete,
    input logic [phmm_occ_pkg::P_W-1:0]        match_to_insert,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic [phmm_occ_pkg::P_W-1:0]        match_occupancy,
    input logic [phmm_occ_pkg::P_W-1:0]        delete_occupancy,
    input logic [phmm_occ_pkg::P_W-1:0]        insert_occupancy,
    input logic                                last_node
);

    // one node in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken while a node is in flight");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(match_occupancy)
            && $stable(delete_occupancy) && $stable(insert_occupancy) && $stable(last_node))
        else $error("stalled result changed");

    a_last_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_node |-> insert_occupancy == '0)
        else $error("insert occupancy on final node");

    a_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> match_occupancy <= phmm_occ_pkg::ONE_Q
            && delete_occupancy <= phmm_occ_pkg::ONE_Q
            && insert_occupancy <= phmm_occ_pkg::ONE_Q)
        else $error("occupancy above one");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("config port not ready");

endmodule

bind profile_hmm_state_occupancy_core phmm_occ_checker u_phmm_occ_checker (.*);

### test/testbench.sv
// testbench for profile_hmm_state_occupancy_core: random and directed node streams,
// self-checking against an in-bench occupancy predictor, apb writes of start_delete_prob
// depends on phmm_occ_pkg and the core rtl
module testbench;

    localparam int PW = phmm_occ_pkg::P_W;
    localparam bit [63:0] UNITY = 64'd1 << phmm_occ_pkg::FRAC_BITS;
    localparam bit [63:0] HALF_LSB = 64'd1 << (phmm_occ_pkg::FRAC_BITS - 1);

    typedef struct packed {
        bit          is_first;
        bit          is_last;
        bit [PW-1:0] begin_prob;
        bit [PW-1:0] mm;
        bit [PW-1:0] md;
        bit [PW-1:0] dm;
        bit [PW-1:0] dd;
        bit [PW-1:0] mi;
    } node_t;

    typedef struct packed {
        bit [PW-1:0] match_occ;
        bit [PW-1:0] delete_occ;
        bit [PW-1:0] insert_occ;
        bit          last_flag;
    } occ_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [phmm_occ_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [phmm_occ_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [phmm_occ_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    logic is_first = 1'b0;
    logic is_last = 1'b0;
    logic [PW-1:0] begin_prob = '0;
    logic [PW-1:0] prev_match_to_match = '0;
    logic [PW-1:0] prev_match_to_delete = '0;
    logic [PW-1:0] prev_delete_to_match = '0;
    logic [PW-1:0] prev_delete_to_delete = '0;
    logic [PW-1:0] match_to_insert = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [PW-1:0] match_occupancy;
    logic [PW-1:0] delete_occupancy;
    logic [PW-1:0] insert_occupancy;
    logic last_node;

    profile_hmm_state_occupancy_core DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .item_valid            (item_valid),
        .item_stall            (item_stall),
        .is_first              (is_first),
        .is_last               (is_last),
        .begin_prob            (begin_prob),
        .prev_match_to_match   (prev_match_to_match),
        .prev_match_to_delete  (prev_match_to_delete),
        .prev_delete_to_match  (prev_delete_to_match),
        .prev_delete_to_delete (prev_delete_to_delete),
        .match_to_insert       (match_to_insert),
        .result_valid          (result_valid),
        .result_stall          (result_stall),
        .match_occupancy       (match_occupancy),
        .delete_occupancy      (delete_occupancy),
        .insert_occupancy      (insert_occupancy),
        .last_node             (last_node)
    );

    node_t pending_nodes[$];
    occ_t  expected_occ[$];
    node_t shown_node;
    int    mismatches = 0;

    bit [PW-1:0] start_delete_cfg = '0;
    bit [63:0]   held_match = '0;
    bit [63:0]   held_delete = '0;
    bit [63:0]   held_insert = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit [63:0] clamp_one(bit [63:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    function automatic bit [63:0] fx_mul(bit [63:0] a, bit [63:0] b);
        return (a * b + HALF_LSB) >> phmm_occ_pkg::FRAC_BITS;
    endfunction

    function automatic bit [63:0] fx_norm(bit [63:0] num, bit [63:0] total);
        if (total == 0)
            return 0;
        return clamp_one((num * UNITY + total / 2) / total);
    endfunction

    // advances the held occupancies by one node
    function automatic occ_t occupancy_step(node_t n);
        bit [63:0] bp, mm, md, dm, dd, mi;
        bit [63:0] m_sum, d_sum, m_new, d_new, i_new;
        occ_t r;
        bp = clamp_one(n.begin_prob);
        mm = clamp_one(n.mm);
        md = clamp_one(n.md);
        dm = clamp_one(n.dm);
        dd = clamp_one(n.dd);
        mi = clamp_one(n.mi);
        d_sum = 0;
        if (n.is_first)
        begin
            m_sum = bp;
            m_new = bp;
            d_new = clamp_one(start_delete_cfg);
        end
        else
        begin
            m_sum = fx_mul(held_match, mm) + held_insert + fx_mul(held_delete, dm) + bp;
            d_sum = fx_mul(held_match, md) + fx_mul(held_delete, dd);
            m_new = fx_norm(m_sum, m_sum + d_sum);
            d_new = fx_norm(d_sum, m_sum + d_sum);
        end
        i_new = n.is_last ? 64'd0 : clamp_one(fx_mul(m_sum, mi));
        held_match = m_new;
        held_delete = d_new;
        held_insert = i_new;
        r.match_occ = m_new[PW-1:0];
        r.delete_occ = d_new[PW-1:0];
        r.insert_occ = i_new[PW-1:0];
        r.last_flag = n.is_last;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // input side: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin : node_driver
        node_t nxt;
        bit offer;
        if (item_valid && !item_stall)
            expected_occ.push_back(occupancy_step(shown_node));
        offer = item_valid && item_stall;
        if (!offer && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_nodes.size() > 0)
            begin
                nxt = pending_nodes.pop_front();
                shown_node = nxt;
                offer = 1'b1;
                is_first <= nxt.is_first;
                is_last <= nxt.is_last;
                begin_prob <= nxt.begin_prob;
                prev_match_to_match <= nxt.mm;
                prev_match_to_delete <= nxt.md;
                prev_delete_to_match <= nxt.dm;
                prev_delete_to_delete <= nxt.dd;
                match_to_insert <= nxt.mi;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
        item_valid <= offer;
    end

    // output side: stall pattern of its own, plus long hold-offs while nodes are offered
    int results_seen = 0;
    int next_hold_at = 120;
    int hold_left = 0;
    int mode_left = 0;
    int stall_mode = 0;
    bit stall_toggle = 1'b0;

    always @(posedge clk)
    begin : result_receiver
        if (result_valid && !result_stall)
            results_seen++;
        if (hold_left == 0 && results_seen >= next_hold_at && item_valid)
        begin
            hold_left = 320;
            next_hold_at += 260;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 120);
            end
            else
                mode_left--;
            stall_toggle = ~stall_toggle;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= stall_toggle;
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        occ_t want;
        if (result_valid && !result_stall)
        begin
            if (expected_occ.size() == 0)
                flag_mismatch("unexpected result, match", match_occupancy, 0);
            else
            begin
                want = expected_occ.pop_front();
                if (match_occupancy !== want.match_occ)
                    flag_mismatch("match_occupancy", match_occupancy, want.match_occ);
                if (delete_occupancy !== want.delete_occ)
                    flag_mismatch("delete_occupancy", delete_occupancy, want.delete_occ);
                if (insert_occupancy !== want.insert_occ)
                    flag_mismatch("insert_occupancy", insert_occupancy, want.insert_occ);
                if (last_node !== want.last_flag)
                    flag_mismatch("last_node", last_node, want.last_flag);
            end
        end
    end

    task automatic write_start_delete(input bit [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= phmm_occ_pkg::ADDR_START_DELETE;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        start_delete_cfg = value[PW-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_node(bit f, bit l, bit [15:0] bp, bit [15:0] mm, bit [15:0] md,
                              bit [15:0] dm, bit [15:0] dd, bit [15:0] mi);
        node_t n;
        n.is_first = f;
        n.is_last = l;
        n.begin_prob = bp;
        n.mm = mm;
        n.md = md;
        n.dm = dm;
        n.dd = dd;
        n.mi = mi;
        pending_nodes.push_back(n);
    endtask

    function automatic bit [15:0] rand_prob(bit wild);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h8000;
            default: return wild ? 16'($urandom_range(0, 65535))
                                 : 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic queue_random_node(bit f, bit l, bit wild);
        queue_node(f, l, rand_prob(wild), rand_prob(wild), rand_prob(wild), rand_prob(wild),
                   rand_prob(wild), rand_prob(wild));
    endtask

    // mostly whole models (first node .. last node), some stray nodes as noise
    task automatic queue_models(int count);
        int added;
        int len;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_random_node($urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
                added++;
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    queue_random_node(k == 0, k == len - 1, $urandom_range(0, 19) == 0);
                added += len;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_nodes.size() != 0 || item_valid || expected_occ.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit [31:0] cfg_values[6];
        wait (rst_n);
        @(posedge clk);
        write_start_delete(32'h0000_2000);

        // non-first nodes straight after reset run on the held zeros
        queue_node(0, 0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_node(0, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        queue_node(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_node(1, 0, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
        queue_node(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_node(0, 1, 16'h1234, 16'h6000, 16'h1000, 16'h3000, 16'h5000, 16'h7FFF);
        queue_node(1, 1, 16'h0000, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h8000);
        // zero path sum
        queue_node(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        queue_node(1, 0, 16'h8001, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h8001);
        queue_node(0, 0, 16'h0001, 16'h7FFF, 16'h0001, 16'h4000, 16'h3FFF, 16'h7FFF);
        queue_node(0, 0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
        queue_node(0, 1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA);
        queue_node(1, 0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        wait_for_drain();

        cfg_values[0] = 32'h0000_0000;
        cfg_values[1] = 32'h0000_8000;
        cfg_values[2] = 32'h0000_FFFF;
        cfg_values[3] = $urandom_range(0, 32768);
        cfg_values[4] = $urandom;
        cfg_values[5] = 32'h0000_0001;
        foreach (cfg_values[p])
        begin
            write_start_delete(cfg_values[p]);
            queue_models(45);
            // sender pauses until every result is back
            wait_for_drain();
            queue_models(45);
            wait_for_drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
